// ===== rtl/tfb_pkg.sv =====
// shared types, constants and functions for the telemetry frame builder
// no dependencies; imported by every module of the block
package tfb_pkg;

    localparam logic [7:0]  FrameStart = 8'hAA;
    localparam logic [15:0] CrcInit    = 16'hFFFF;
    localparam logic [15:0] CrcPoly    = 16'h1021;
    localparam int          FrameLen   = 17;
    localparam int          CrcSpan    = 15;
    localparam int          IdxW       = $clog2(FrameLen);
    localparam logic [IdxW-1:0] LastIdx = IdxW'(FrameLen - 1);
    localparam logic [IdxW-1:0] CrcEnd  = IdxW'(CrcSpan);

    typedef struct packed {
        logic [7:0]  sequence_req;
        logic [31:0] yaw_bits;
        logic [31:0] pitch_bits;
        logic [31:0] roll_bits;
        logic [7:0]  status_flags;
    } t_rec;

    typedef struct packed {
        logic clear;
        logic step;
    } t_crc_ctrl;

    // msb-first crc-16 update over one byte, eight shift steps
    function automatic logic [15:0] crc_byte(input logic [15:0] acc, input logic [7:0] octet);
        logic [15:0] c;
        c = acc ^ {octet, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CrcPoly;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    // byte of the frame at a given position, angle words low byte first
    function automatic logic [7:0] frame_byte_at(input t_rec rec, input logic [IdxW-1:0] idx,
                                                 input logic [15:0] crc);
        logic [7:0] b;
        case (idx)
            5'd0:    b = FrameStart;
            5'd1:    b = rec.sequence_req;
            5'd2:    b = rec.yaw_bits[7:0];
            5'd3:    b = rec.yaw_bits[15:8];
            5'd4:    b = rec.yaw_bits[23:16];
            5'd5:    b = rec.yaw_bits[31:24];
            5'd6:    b = rec.pitch_bits[7:0];
            5'd7:    b = rec.pitch_bits[15:8];
            5'd8:    b = rec.pitch_bits[23:16];
            5'd9:    b = rec.pitch_bits[31:24];
            5'd10:   b = rec.roll_bits[7:0];
            5'd11:   b = rec.roll_bits[15:8];
            5'd12:   b = rec.roll_bits[23:16];
            5'd13:   b = rec.roll_bits[31:24];
            5'd14:   b = rec.status_flags;
            5'd15:   b = crc[7:0];
            5'd16:   b = crc[15:8];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/tfb_crc_unit.sv =====
// running crc-16 register, one byte folded in per step
// depends on tfb_pkg
module tfb_crc_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tfb_pkg::t_crc_ctrl i_ctrl,
    input  logic [7:0]         i_byte,
    output logic [15:0]        o_crc
);
    import tfb_pkg::*;

    logic [15:0] r_crc;
    logic [15:0] n_crc;

    always_comb begin
        n_crc = r_crc;
        if (i_ctrl.clear) begin
            n_crc = CrcInit;
        end else if (i_ctrl.step) begin
            n_crc = crc_byte(r_crc, i_byte);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= CrcInit;
        end else begin
            r_crc <= n_crc;
        end
    end

    assign o_crc = r_crc;

endmodule

// ===== rtl/tfb_out_reg.sv =====
// result register for the byte stream, loads whenever empty or drained
// depends on tfb_pkg
module tfb_out_reg (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    input  logic       i_ready,
    output logic       o_free,
    output logic       o_valid,
    output logic [7:0] o_frame_byte,
    output logic       o_last_byte
);
    import tfb_pkg::*;

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;

    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_byte <= i_byte;
            r_last <= i_last;
        end
    end

    assign o_valid      = r_valid;
    assign o_frame_byte = r_byte;
    assign o_last_byte  = r_last;

endmodule

// ===== rtl/telemetry_frame_builder_crc16_top.sv =====
// accepting an item loads the record register; its first byte then loads the output register once that is free
// one frame byte per cycle on the output port while the receiver holds i_ready high
// the next item is taken in the cycle the last byte of the current frame loads the output register
// reset (synchronous, active low) clears the busy flag and the output valid flag and sets the crc to its init value
// depends on tfb_pkg, tfb_crc_unit, tfb_out_reg
module telemetry_frame_builder_crc16_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_sequence_req,
    input  logic [31:0] i_yaw_bits,
    input  logic [31:0] i_pitch_bits,
    input  logic [31:0] i_roll_bits,
    input  logic [7:0]  i_status_flags,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_frame_byte,
    output logic        o_last_byte
);
    import tfb_pkg::*;

    logic            r_busy;
    logic [IdxW-1:0] r_idx;
    t_rec            r_rec;

    logic            out_free;
    logic            emit;
    logic            end_frame;
    logic            accept;
    logic [15:0]     crc;
    logic [7:0]      cur_byte;
    t_crc_ctrl       crc_ctrl;

    assign emit      = r_busy && out_free;
    assign end_frame = emit && (r_idx == LastIdx);
    assign o_ready   = !r_busy || end_frame;
    assign accept    = i_valid && o_ready;
    assign cur_byte  = frame_byte_at(r_rec, r_idx, crc);

    assign crc_ctrl.clear = accept;
    assign crc_ctrl.step  = emit && (r_idx < CrcEnd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (accept) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (emit) begin
            r_busy <= !end_frame;
            r_idx  <= r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rec.sequence_req <= i_sequence_req;
            r_rec.yaw_bits     <= i_yaw_bits;
            r_rec.pitch_bits   <= i_pitch_bits;
            r_rec.roll_bits    <= i_roll_bits;
            r_rec.status_flags <= i_status_flags;
        end
    end

    tfb_crc_unit u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (crc_ctrl),
        .i_byte  (cur_byte),
        .o_crc   (crc)
    );

    tfb_out_reg u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (r_busy),
        .i_byte       (cur_byte),
        .i_last       (r_idx == LastIdx),
        .i_ready      (i_ready),
        .o_free       (out_free),
        .o_valid      (o_valid),
        .o_frame_byte (o_frame_byte),
        .o_last_byte  (o_last_byte)
    );

    // a new item starts its frame at the start byte
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_busy && r_idx == '0))
        else $error("frame did not restart after item accepted");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx <= LastIdx))
        else $error("frame index out of range");

    // an item is only taken mid-frame when the final byte leaves
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_busy) |-> (r_idx == LastIdx && out_free))
        else $error("item accepted while frame in progress");

    a_last_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        end_frame |=> (o_valid && o_last_byte))
        else $error("final byte not marked");

endmodule

// ===== bench/tb_top.sv =====
// self-checking bench for telemetry_frame_builder_crc16_top: telemetry records in,
// 17-byte crc framed byte stream out; scoreboard class predicts every frame byte
// depends on rtl/tfb_pkg.sv and rtl/telemetry_frame_builder_crc16_top.sv
`timescale 1ns / 1ps

module tb_top;
    import tfb_pkg::*;

    localparam int RandomRecords = 268;
    localparam int BurstFrom     = 120;    // sender offers back to back in this range
    localparam int BurstTo       = 170;
    localparam int HoldAtByte    = 17 * 130;
    localparam int HoldCycles    = 300;
    localparam int EagerFrom     = 3000;   // receiver never stalls in this byte range
    localparam int EagerTo       = 3600;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_frame_beat;

    class frame_scoreboard;
        t_frame_beat pending[$];
        int          errors;
        int          records_noted;
        int          bytes_checked;

        function new();
            errors        = 0;
            records_noted = 0;
            bytes_checked = 0;
        endfunction

        // builds the whole frame of one record and queues its bytes in send order
        function void note_record(t_rec rec);
            logic [7:0]  body[15];
            logic [15:0] crc;
            logic        fb;
            t_frame_beat beat;
            body[0]  = FrameStart;
            body[1]  = rec.sequence_req;
            for (int k = 0; k < 4; k++) begin
                body[2 + k]  = rec.yaw_bits[8*k +: 8];
                body[6 + k]  = rec.pitch_bits[8*k +: 8];
                body[10 + k] = rec.roll_bits[8*k +: 8];
            end
            body[14] = rec.status_flags;
            // bit-serial crc, data msb first
            crc = 16'hFFFF;
            for (int n = 0; n < 15; n++) begin
                for (int b = 7; b >= 0; b--) begin
                    fb  = crc[15] ^ body[n][b];
                    crc = {crc[14:0], 1'b0};
                    if (fb) crc = crc ^ 16'h1021;
                end
            end
            for (int n = 0; n < 15; n++) begin
                beat.data = body[n];
                beat.last = 1'b0;
                pending.push_back(beat);
            end
            beat.data = crc[7:0];
            beat.last = 1'b0;
            pending.push_back(beat);
            beat.data = crc[15:8];
            beat.last = 1'b1;
            pending.push_back(beat);
            records_noted++;
        endfunction

        function void check_byte(logic [7:0] data, logic last);
            t_frame_beat want;
            if (pending.size() == 0) begin
                $error("frame_byte: no byte expected, got %02h (last_byte %0b)", data, last);
                errors++;
                return;
            end
            want = pending.pop_front();
            bytes_checked++;
            if (data !== want.data) begin
                $error("frame_byte: expected %02h, got %02h", want.data, data);
                errors++;
            end
            if (last !== want.last) begin
                $error("last_byte: expected %0b, got %0b", want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_sequence_req;
    logic [31:0] i_yaw_bits;
    logic [31:0] i_pitch_bits;
    logic [31:0] i_roll_bits;
    logic [7:0]  i_status_flags;
    logic        o_valid;
    logic        i_ready;
    logic [7:0]  o_frame_byte;
    logic        o_last_byte;

    frame_scoreboard sb;
    int              records_sent;
    int              bytes_taken;
    int              hold_cycles_done;

    telemetry_frame_builder_crc16_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_sequence_req (i_sequence_req),
        .i_yaw_bits     (i_yaw_bits),
        .i_pitch_bits   (i_pitch_bits),
        .i_roll_bits    (i_roll_bits),
        .i_status_flags (i_status_flags),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_frame_byte   (o_frame_byte),
        .o_last_byte    (o_last_byte)
    );

    always #6 i_clk = ~i_clk;

    // both handshakes are sampled on the edge, before any update from that edge lands
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                t_rec rec;
                rec.sequence_req = i_sequence_req;
                rec.yaw_bits     = i_yaw_bits;
                rec.pitch_bits   = i_pitch_bits;
                rec.roll_bits    = i_roll_bits;
                rec.status_flags = i_status_flags;
                sb.note_record(rec);
            end
            if (o_valid && i_ready) begin
                sb.check_byte(o_frame_byte, o_last_byte);
            end
        end
    end

    // called at a rising edge; valid stays high across a zero gap
    task automatic offer_record(input t_rec rec, input int gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_sequence_req <= rec.sequence_req;
        i_yaw_bits     <= rec.yaw_bits;
        i_pitch_bits   <= rec.pitch_bits;
        i_roll_bits    <= rec.roll_bits;
        i_status_flags <= rec.status_flags;
        do @(posedge i_clk); while (!o_ready);
        records_sent++;
    endtask

    // mostly plain random words, with float corner patterns mixed in
    function automatic logic [31:0] random_word();
        logic [31:0] odd_words[8] = '{32'h7FC00000, 32'h7F800000, 32'hFF800000, 32'h00000001,
                                      32'h80000000, 32'h007FFFFF, 32'hFFFFFFFF, 32'h00000000};
        if ($urandom_range(0, 5) == 0) return odd_words[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    function automatic int sender_gap();
        if (records_sent >= BurstFrom && records_sent < BurstTo) return 0;
        return $urandom_range(0, 7);
    endfunction

    initial begin
        logic [31:0] corner[12] = '{32'h00000000, 32'hFFFFFFFF, 32'h7FC00000, 32'h7F800000,
                                    32'hFF800000, 32'h00000001, 32'h80000000, 32'h3F800000,
                                    32'h7FFFFFFF, 32'h807FFFFF, 32'hAAAAAAAA, 32'h55555555};
        t_rec rec;
        sb               = new();
        records_sent     = 0;
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_sequence_req <= '0;
        i_yaw_bits     <= '0;
        i_pitch_bits   <= '0;
        i_roll_bits    <= '0;
        i_status_flags <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // field extremes and nan, infinity, signed zero and denormal angle patterns
        for (int i = 0; i < 12; i++) begin
            rec.sequence_req = i[0] ? 8'hFF : 8'h00;
            rec.status_flags = i[1] ? 8'hFF : 8'h00;
            rec.yaw_bits     = corner[i];
            rec.pitch_bits   = corner[(i + 4) % 12];
            rec.roll_bits    = corner[(i + 8) % 12];
            offer_record(rec, sender_gap());
        end

        for (int i = 0; i < RandomRecords; i++) begin
            rec.sequence_req = $urandom_range(0, 255);
            rec.yaw_bits     = random_word();
            rec.pitch_bits   = random_word();
            rec.roll_bits    = random_word();
            rec.status_flags = $urandom_range(0, 255);
            offer_record(rec, sender_gap());
        end
        i_valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("tb_top: %0d records framed, %0d frame bytes checked, %0d mismatches",
                 sb.records_noted, sb.bytes_checked, sb.errors);
        $display("tb_top: random idles on both sides, one %0d-cycle receiver hold-off",
                 hold_cycles_done);
        if (sb.errors == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    // byte receiver: random stalls, one long hold-off so the input backs up
    initial begin
        int stall;
        bytes_taken      = 0;
        hold_cycles_done = 0;
        i_ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (bytes_taken >= EagerFrom && bytes_taken < EagerTo) begin
                stall = 0;
            end else begin
                stall = $urandom_range(0, 7);
            end
            if (bytes_taken == HoldAtByte) stall = HoldCycles;
            if (stall > 0) begin
                i_ready <= 1'b0;
                for (int c = 0; c < stall; c++) begin
                    @(posedge i_clk);
                    if (stall == HoldCycles) hold_cycles_done++;
                end
                i_ready <= 1'b1;
            end else begin
                i_ready <= 1'b1;
            end
            do @(posedge i_clk); while (!o_valid);
            bytes_taken++;
        end
    end

    initial begin
        #5_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
